// ----- hdl/triangle_midpoint_subdivider_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the triangle midpoint subdivider
// Implication checks sampled on the rising clock edge, held off during reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_MIDPOINT_SUBDIVIDER_ASSERT_SVH
`define TRIANGLE_MIDPOINT_SUBDIVIDER_ASSERT_SVH

// same-cycle implication
`define TMSUB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("tmsub assertion failed");

// next-cycle implication
`define TMSUB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("tmsub assertion failed");

`endif

// ----- hdl/tmsub_pkg.sv -----
// ----------------------------------------------------------------------------
// tmsub_pkg
// Shared widths, types, state codes and the output index list.
// ----------------------------------------------------------------------------
package tmsub_pkg;

	localparam int POS_W          = 32;
	localparam int NORM_W         = 16;
	localparam int TEX_W          = 16;
	localparam int IDX_W          = 32;
	localparam int NORM_FRAC_BITS = 14;
	localparam int SUM_W          = NORM_W + 1;                  // sum of two normals
	localparam int SQ_W           = 2 * SUM_W + 2;               // squared length, even
	localparam int LEN_W          = SQ_W / 2;                    // root width
	localparam int DIV_W          = SUM_W + NORM_FRAC_BITS + 1;  // dividend width
	localparam int ITER_W         = $clog2(DIV_W + 1);
	localparam int K_W            = 3;

	localparam logic [K_W-1:0] K_LAST_CORNER = K_W'(2);
	localparam logic [K_W-1:0] K_MID_01      = K_W'(3);
	localparam logic [K_W-1:0] K_MID_12      = K_W'(4);
	localparam logic [K_W-1:0] K_LAST        = K_W'(5);

	typedef struct packed {
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
		logic signed [NORM_W-1:0] norm_x;
		logic signed [NORM_W-1:0] norm_y;
		logic signed [NORM_W-1:0] norm_z;
		logic [TEX_W-1:0]         tex_u;
		logic [TEX_W-1:0]         tex_v;
	} vertex_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CORNER,
		ST_LOAD,
		ST_CALC,
		ST_MID
	} ctrl_state_t;

	typedef enum logic [2:0] {
		NP_IDLE,
		NP_SQ,
		NP_SQRT,
		NP_DLOAD,
		NP_DIV
	} norm_phase_t;

	typedef struct packed {
		logic           take;
		logic           norm_start;
		logic           tri_done;
		logic [K_W-1:0] k;
	} cmd_t;

	typedef struct packed {
		logic trig;
		logic norm_busy;
	} status_t;

	// index list {0,3,5, 3,4,5, 5,4,2, 3,1,4}
	function automatic logic [2:0] idx_entry(input logic [3:0] e);
		logic [2:0] v;
		unique case (e)
			4'd0:    v = 3'd0;
			4'd1:    v = 3'd3;
			4'd2:    v = 3'd5;
			4'd3:    v = 3'd3;
			4'd4:    v = 3'd4;
			4'd5:    v = 3'd5;
			4'd6:    v = 3'd5;
			4'd7:    v = 3'd4;
			4'd8:    v = 3'd2;
			4'd9:    v = 3'd3;
			4'd10:   v = 3'd1;
			4'd11:   v = 3'd4;
			default: v = 3'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- hdl/tmsub_vtx_if.sv -----
// ----------------------------------------------------------------------------
// tmsub_vtx_if
// Input vertex channel: valid/ready with one vertex and the restart flag.
// ----------------------------------------------------------------------------
interface tmsub_vtx_if;
	logic                                         valid;
	logic                                         ready;
	logic signed [tmsub_pkg::POS_W-1:0]  pos_x;
	logic signed [tmsub_pkg::POS_W-1:0]  pos_y;
	logic signed [tmsub_pkg::POS_W-1:0]  pos_z;
	logic signed [tmsub_pkg::NORM_W-1:0] norm_x;
	logic signed [tmsub_pkg::NORM_W-1:0] norm_y;
	logic signed [tmsub_pkg::NORM_W-1:0] norm_z;
	logic [tmsub_pkg::TEX_W-1:0]         tex_u;
	logic [tmsub_pkg::TEX_W-1:0]         tex_v;
	logic                                         restart;

	modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
		tex_u, tex_v, restart, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
		tex_u, tex_v, restart, output ready);
endinterface

// ----- hdl/tmsub_res_if.sv -----
// ----------------------------------------------------------------------------
// tmsub_res_if
// Result vertex channel: valid/ready with one emitted vertex and its indices.
// ----------------------------------------------------------------------------
interface tmsub_res_if;
	logic                                         valid;
	logic                                         ready;
	logic signed [tmsub_pkg::POS_W-1:0]  out_pos_x;
	logic signed [tmsub_pkg::POS_W-1:0]  out_pos_y;
	logic signed [tmsub_pkg::POS_W-1:0]  out_pos_z;
	logic signed [tmsub_pkg::NORM_W-1:0] out_norm_x;
	logic signed [tmsub_pkg::NORM_W-1:0] out_norm_y;
	logic signed [tmsub_pkg::NORM_W-1:0] out_norm_z;
	logic [tmsub_pkg::TEX_W-1:0]         out_tex_u;
	logic [tmsub_pkg::TEX_W-1:0]         out_tex_v;
	logic [tmsub_pkg::IDX_W-1:0]         vertex_number;
	logic [tmsub_pkg::IDX_W-1:0]         index_first;
	logic [tmsub_pkg::IDX_W-1:0]         index_second;
	logic                                         last;

	modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_norm_x,
		out_norm_y, out_norm_z, out_tex_u, out_tex_v, vertex_number, index_first,
		index_second, last, input ready);
	modport sink (input valid, out_pos_x, out_pos_y, out_pos_z, out_norm_x,
		out_norm_y, out_norm_z, out_tex_u, out_tex_v, vertex_number, index_first,
		index_second, last, output ready);
endinterface

// ----- hdl/tmsub_norm.sv -----
// ----------------------------------------------------------------------------
// tmsub_norm
// Iterative renormaliser: squared length with one multiplier, bit-pair square
// root, then one restoring division per component with rounding and clamping.
// ----------------------------------------------------------------------------
module tmsub_norm (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic signed [tmsub_pkg::SUM_W-1:0]      sum_x,
	input  logic signed [tmsub_pkg::SUM_W-1:0]      sum_y,
	input  logic signed [tmsub_pkg::SUM_W-1:0]      sum_z,
	output logic                                    busy,
	output logic signed [tmsub_pkg::NORM_W-1:0]     norm_x,
	output logic signed [tmsub_pkg::NORM_W-1:0]     norm_y,
	output logic signed [tmsub_pkg::NORM_W-1:0]     norm_z
);

	localparam int SUM_W  = tmsub_pkg::SUM_W;
	localparam int SQ_W   = tmsub_pkg::SQ_W;
	localparam int LEN_W  = tmsub_pkg::LEN_W;
	localparam int DIV_W  = tmsub_pkg::DIV_W;
	localparam int NORM_W = tmsub_pkg::NORM_W;
	localparam int NF     = tmsub_pkg::NORM_FRAC_BITS;
	localparam int ITER_W = tmsub_pkg::ITER_W;
	localparam logic [DIV_W-1:0] POS_LIM = DIV_W'((1 << (NORM_W - 1)) - 1);
	localparam logic [DIV_W-1:0] NEG_LIM = DIV_W'(1 << (NORM_W - 1));

	tmsub_pkg::norm_phase_t       phase_q, phase_d;
	logic signed [SUM_W-1:0]      s_q [3];
	logic signed [NORM_W-1:0]     n_q [3];
	logic [1:0]                   c_q;
	logic [ITER_W-1:0]            it_q;
	logic [SQ_W-1:0]              acc_q, x_q, root_q, one_q;
	logic [LEN_W-1:0]             len_q, rem_q;
	logic [DIV_W-1:0]             dvd_q, quo_q;

	logic signed [2*SUM_W-1:0]    sq;
	logic [SQ_W-1:0]              acc_nx, root_nx, trial_sq;
	logic [SUM_W-1:0]             mag;
	logic [LEN_W:0]               trial;
	logic                         qbit;
	logic [LEN_W-1:0]             rem_nx;
	logic [DIV_W-1:0]             quo_nx;
	logic                         neg;
	logic signed [NORM_W-1:0]     n_sat;

	always_comb begin
		sq       = s_q[c_q] * s_q[c_q];
		acc_nx   = acc_q + SQ_W'(unsigned'(sq));
		trial_sq = root_q + one_q;
		root_nx  = (x_q >= trial_sq) ? ((root_q >> 1) + one_q) : (root_q >> 1);
		neg      = s_q[c_q][SUM_W-1];
		mag      = neg ? (SUM_W'(0) - s_q[c_q]) : s_q[c_q];
		trial    = {rem_q, dvd_q[DIV_W-1]};
		qbit     = (trial >= {1'b0, len_q});
		rem_nx   = qbit ? LEN_W'(trial - {1'b0, len_q}) : trial[LEN_W-1:0];
		quo_nx   = {quo_q[DIV_W-2:0], qbit};
		if (!neg) begin
			n_sat = (quo_nx > POS_LIM) ? NORM_W'(POS_LIM) : NORM_W'(quo_nx);
		end else begin
			n_sat = (quo_nx > NEG_LIM) ? NORM_W'(NEG_LIM) :
				NORM_W'(NORM_W'(0) - quo_nx[NORM_W-1:0]);
		end
	end

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			tmsub_pkg::NP_IDLE: begin
				if (start) begin
					phase_d = tmsub_pkg::NP_SQ;
				end
			end
			tmsub_pkg::NP_SQ: begin
				if (c_q == 2'd2) begin
					// zero-length sum gives a zero normal
					phase_d = (acc_nx == '0) ? tmsub_pkg::NP_IDLE : tmsub_pkg::NP_SQRT;
				end
			end
			tmsub_pkg::NP_SQRT: begin
				if (it_q == ITER_W'(LEN_W - 1)) begin
					phase_d = tmsub_pkg::NP_DLOAD;
				end
			end
			tmsub_pkg::NP_DLOAD: begin
				phase_d = tmsub_pkg::NP_DIV;
			end
			tmsub_pkg::NP_DIV: begin
				if (it_q == ITER_W'(DIV_W - 1)) begin
					phase_d = (c_q == 2'd2) ? tmsub_pkg::NP_IDLE : tmsub_pkg::NP_DLOAD;
				end
			end
			default: phase_d = tmsub_pkg::NP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tmsub_pkg::NP_IDLE;
			c_q     <= '0;
			it_q    <= '0;
		end else begin
			phase_q <= phase_d;
			case (phase_q)
				tmsub_pkg::NP_IDLE: begin
					if (start) begin
						c_q <= '0;
					end
				end
				tmsub_pkg::NP_SQ: begin
					if (c_q == 2'd2) begin
						it_q <= '0;
					end else begin
						c_q <= c_q + 2'd1;
					end
				end
				tmsub_pkg::NP_SQRT: begin
					it_q <= it_q + ITER_W'(1);
					if (it_q == ITER_W'(LEN_W - 1)) begin
						c_q <= '0;
					end
				end
				tmsub_pkg::NP_DLOAD: begin
					it_q <= '0;
				end
				tmsub_pkg::NP_DIV: begin
					it_q <= it_q + ITER_W'(1);
					if (it_q == ITER_W'(DIV_W - 1) && c_q != 2'd2) begin
						c_q <= c_q + 2'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			tmsub_pkg::NP_IDLE: begin
				if (start) begin
					s_q[0] <= sum_x;
					s_q[1] <= sum_y;
					s_q[2] <= sum_z;
					acc_q  <= '0;
				end
			end
			tmsub_pkg::NP_SQ: begin
				acc_q <= acc_nx;
				if (c_q == 2'd2) begin
					x_q    <= acc_nx;
					root_q <= '0;
					one_q  <= SQ_W'(1) << (SQ_W - 2);
					if (acc_nx == '0) begin
						n_q[0] <= '0;
						n_q[1] <= '0;
						n_q[2] <= '0;
					end
				end
			end
			tmsub_pkg::NP_SQRT: begin
				if (x_q >= trial_sq) begin
					x_q <= x_q - trial_sq;
				end
				root_q <= root_nx;
				one_q  <= one_q >> 2;
				len_q  <= root_nx[LEN_W-1:0];
			end
			tmsub_pkg::NP_DLOAD: begin
				dvd_q <= (DIV_W'(mag) << NF) + DIV_W'(len_q >> 1);
				rem_q <= '0;
				quo_q <= '0;
			end
			tmsub_pkg::NP_DIV: begin
				dvd_q <= dvd_q << 1;
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				if (it_q == ITER_W'(DIV_W - 1)) begin
					n_q[c_q] <= n_sat;
				end
			end
			default: ;
		endcase
	end

	assign busy   = (phase_q != tmsub_pkg::NP_IDLE);
	assign norm_x = n_q[0];
	assign norm_y = n_q[1];
	assign norm_z = n_q[2];

endmodule

// ----- hdl/tmsub_dp.sv -----
// ----------------------------------------------------------------------------
// tmsub_dp
// Datapath: held vertices, slot and triangle count, midpoint arithmetic and
// the result selection.
// ----------------------------------------------------------------------------
module tmsub_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tmsub_pkg::cmd_t                     cmd,
	output tmsub_pkg::status_t                  status,
	input  tmsub_pkg::vertex_t                  vtx_in,
	input  logic                                restart,
	output tmsub_pkg::vertex_t                  vtx_out,
	output logic [tmsub_pkg::IDX_W-1:0]         vertex_number,
	output logic [tmsub_pkg::IDX_W-1:0]         index_first,
	output logic [tmsub_pkg::IDX_W-1:0]         index_second,
	output logic                                last
);

	localparam int POS_W = tmsub_pkg::POS_W;
	localparam int TEX_W = tmsub_pkg::TEX_W;
	localparam int IDX_W = tmsub_pkg::IDX_W;
	localparam int SUM_W = tmsub_pkg::SUM_W;

	tmsub_pkg::vertex_t v_q [3];
	logic [1:0]         slot_q;
	logic [IDX_W-1:0]   count_q;

	logic [1:0]         slot_eff;
	tmsub_pkg::vertex_t va, vb, mid;
	logic               norm_busy;
	logic [IDX_W-1:0]   base;
	logic [3:0]         e0;
	logic signed [tmsub_pkg::NORM_W-1:0] nx, ny, nz;

	function automatic logic [POS_W-1:0] avg_pos(input logic [POS_W-1:0] a,
		input logic [POS_W-1:0] b);
		logic [POS_W:0] s;
		s = {a[POS_W-1], a} + {b[POS_W-1], b};
		return s[POS_W:1];
	endfunction

	function automatic logic [TEX_W-1:0] avg_tex(input logic [TEX_W-1:0] a,
		input logic [TEX_W-1:0] b);
		logic [TEX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TEX_W:1];
	endfunction

	assign slot_eff    = restart ? 2'd0 : slot_q;
	assign status.trig = (slot_eff == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.take) begin
				slot_q <= (slot_eff == 2'd2) ? 2'd0 : slot_eff + 2'd1;
				if (restart) begin
					count_q <= '0;
				end
			end else if (cmd.tri_done) begin
				count_q <= count_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			v_q[slot_eff] <= vtx_in;
		end
	end

	// midpoint pairs: 3 is v0-v1, 4 is v1-v2, 5 is v0-v2
	always_comb begin
		va = (cmd.k == tmsub_pkg::K_MID_12) ? v_q[1] : v_q[0];
		vb = (cmd.k == tmsub_pkg::K_MID_01) ? v_q[1] : v_q[2];
	end

	tmsub_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.norm_start),
		.sum_x  (SUM_W'(va.norm_x) + SUM_W'(vb.norm_x)),
		.sum_y  (SUM_W'(va.norm_y) + SUM_W'(vb.norm_y)),
		.sum_z  (SUM_W'(va.norm_z) + SUM_W'(vb.norm_z)),
		.busy   (norm_busy),
		.norm_x (nx),
		.norm_y (ny),
		.norm_z (nz)
	);

	assign status.norm_busy = norm_busy;

	always_comb begin
		mid.pos_x  = avg_pos(va.pos_x, vb.pos_x);
		mid.pos_y  = avg_pos(va.pos_y, vb.pos_y);
		mid.pos_z  = avg_pos(va.pos_z, vb.pos_z);
		mid.norm_x = nx;
		mid.norm_y = ny;
		mid.norm_z = nz;
		mid.tex_u  = avg_tex(va.tex_u, vb.tex_u);
		mid.tex_v  = avg_tex(va.tex_v, vb.tex_v);
		vtx_out    = (cmd.k > tmsub_pkg::K_LAST_CORNER) ? mid : v_q[cmd.k[1:0]];
	end

	always_comb begin
		base          = {count_q[IDX_W-3:0], 2'b00} + {count_q[IDX_W-2:0], 1'b0};
		e0            = {cmd.k, 1'b0};
		vertex_number = base + IDX_W'(cmd.k);
		index_first   = base + IDX_W'(tmsub_pkg::idx_entry(e0));
		index_second  = base + IDX_W'(tmsub_pkg::idx_entry(e0 | 4'd1));
		last          = (cmd.k == tmsub_pkg::K_LAST);
	end

endmodule

// ----- hdl/tmsub_ctrl.sv -----
// ----------------------------------------------------------------------------
// tmsub_ctrl
// Controller: takes vertices, steps through the six results of a triangle
// and starts the renormaliser for each midpoint.
// ----------------------------------------------------------------------------
`include "triangle_midpoint_subdivider_assert.svh"

module tmsub_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  tmsub_pkg::status_t   status,
	output tmsub_pkg::cmd_t      cmd
);

	localparam int K_W = tmsub_pkg::K_W;

	tmsub_pkg::ctrl_state_t state_q, state_d;
	logic [K_W-1:0]         k_q, k_d;
	logic                   in_calc, k_mid, at_rest;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmsub_pkg::ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		k_d            = k_q;
		in_ready       = 1'b0;
		out_valid      = 1'b0;
		cmd.take       = 1'b0;
		cmd.norm_start = 1'b0;
		cmd.tri_done   = 1'b0;
		cmd.k          = k_q;
		unique case (state_q)
			tmsub_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				k_d      = '0;
				if (in_valid && status.trig) begin
					state_d = tmsub_pkg::ST_CORNER;
				end
			end
			tmsub_pkg::ST_CORNER: begin
				out_valid = 1'b1;
				if (out_ready) begin
					k_d = k_q + K_W'(1);
					if (k_q == tmsub_pkg::K_LAST_CORNER) begin
						state_d = tmsub_pkg::ST_LOAD;
					end
				end
			end
			tmsub_pkg::ST_LOAD: begin
				cmd.norm_start = 1'b1;
				state_d        = tmsub_pkg::ST_CALC;
			end
			tmsub_pkg::ST_CALC: begin
				if (!status.norm_busy) begin
					state_d = tmsub_pkg::ST_MID;
				end
			end
			tmsub_pkg::ST_MID: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (k_q == tmsub_pkg::K_LAST) begin
						cmd.tri_done = 1'b1;
						k_d          = '0;
						state_d      = tmsub_pkg::ST_IDLE;
					end else begin
						k_d     = k_q + K_W'(1);
						state_d = tmsub_pkg::ST_LOAD;
					end
				end
			end
			default: state_d = tmsub_pkg::ST_IDLE;
		endcase
	end

	assign in_calc = (state_q == tmsub_pkg::ST_CALC);
	assign k_mid   = (k_q >= tmsub_pkg::K_MID_01) && (k_q <= tmsub_pkg::K_LAST);
	assign at_rest = (state_q == tmsub_pkg::ST_IDLE) && (k_q == '0);

	`TMSUB_ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	`TMSUB_ASSERT_IMP(a_mid_k, clk, arst_n, in_calc, k_mid)
	`TMSUB_ASSERT_NXT(a_done_idle, clk, arst_n, cmd.tri_done, at_rest)
	`TMSUB_ASSERT_NXT(a_start_busy, clk, arst_n, cmd.norm_start, status.norm_busy)

endmodule

// ----- hdl/triangle_midpoint_subdivider.sv -----
// ----------------------------------------------------------------------------
// triangle_midpoint_subdivider
// One-to-four midpoint subdivision of a triangle list, one vertex a request.
// ----------------------------------------------------------------------------
// The first two vertices of a triangle are each taken and held. The third
// vertex starts six results: the three corners go out one a cycle while the
// output is not held off, then for each edge midpoint the controller starts
// the shared renormaliser, which forms the squared length of the normal sum,
// takes eighteen square root steps and does one restoring division per
// normal component; the controller then sees it finish and presents the
// result. No vertex is taken while results are pending. A zero-length
// normal sum skips the root and division.
module triangle_midpoint_subdivider (
	input  logic         clk,
	input  logic         arst_n,
	tmsub_vtx_if.sink    vtx,
	tmsub_res_if.source  res
);

	tmsub_pkg::cmd_t    cmd;
	tmsub_pkg::status_t status;
	tmsub_pkg::vertex_t vtx_in, vtx_out;

	assign vtx_in.pos_x  = vtx.pos_x;
	assign vtx_in.pos_y  = vtx.pos_y;
	assign vtx_in.pos_z  = vtx.pos_z;
	assign vtx_in.norm_x = vtx.norm_x;
	assign vtx_in.norm_y = vtx.norm_y;
	assign vtx_in.norm_z = vtx.norm_z;
	assign vtx_in.tex_u  = vtx.tex_u;
	assign vtx_in.tex_v  = vtx.tex_v;

	tmsub_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vtx.valid),
		.in_ready  (vtx.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.status    (status),
		.cmd       (cmd)
	);

	tmsub_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.vtx_in        (vtx_in),
		.restart       (vtx.restart),
		.vtx_out       (vtx_out),
		.vertex_number (res.vertex_number),
		.index_first   (res.index_first),
		.index_second  (res.index_second),
		.last          (res.last)
	);

	assign res.out_pos_x  = vtx_out.pos_x;
	assign res.out_pos_y  = vtx_out.pos_y;
	assign res.out_pos_z  = vtx_out.pos_z;
	assign res.out_norm_x = vtx_out.norm_x;
	assign res.out_norm_y = vtx_out.norm_y;
	assign res.out_norm_z = vtx_out.norm_z;
	assign res.out_tex_u  = vtx_out.tex_u;
	assign res.out_tex_v  = vtx_out.tex_v;

endmodule
